[rtl/shwd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// shwd_pkg
// Shared types, constants and helpers for the sync header word deframer.
// -----------------------------------------------------------------------------
package shwd_pkg;

	localparam int BYTES_PER_WORD = 4;
	localparam int POS_W          = $clog2(BYTES_PER_WORD + 1);
	localparam int WORD_W         = 32;
	localparam int CAT_W          = (BYTES_PER_WORD * 8 > WORD_W) ? BYTES_PER_WORD * 8 : WORD_W;

	localparam int NUM_REGS = 4;
	localparam int ADDR_W   = $clog2(NUM_REGS * 4);
	localparam int DATA_W   = 32;

	localparam logic [7:0] HEADER_BYTE_RST     = 8'hAA;
	localparam logic [7:0] HEADER_NEEDED_RST   = 8'd5;
	localparam logic [7:0] DELIMITER_BYTE_RST  = 8'hDD;
	localparam logic [7:0] WORDS_PER_FRAME_RST = 8'd3;

	typedef enum logic [1:0] {
		REG_HEADER_BYTE     = 2'd0,
		REG_HEADER_NEEDED   = 2'd1,
		REG_DELIMITER_BYTE  = 2'd2,
		REG_WORDS_PER_FRAME = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] header_byte;
		logic [7:0] header_needed;
		logic [7:0] delimiter_byte;
		logic [7:0] words_per_frame;
	} cfg_t;

	typedef logic [BYTES_PER_WORD-1:0][7:0] byte_buf_t;

	// slot 0 most significant; only the low word is kept
	function automatic logic [WORD_W-1:0] build_word(input byte_buf_t b);
		logic [CAT_W-1:0] cat;
		cat = '0;
		for (int k = 0; k < BYTES_PER_WORD; k++) begin
			cat[(BYTES_PER_WORD-1-k)*8 +: 8] = b[k];
		end
		return cat[WORD_W-1:0];
	endfunction

endpackage
`default_nettype wire

[rtl/shwd_byte_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// shwd_byte_if
// Valid/ready channel carrying one received byte per beat.
// -----------------------------------------------------------------------------
interface shwd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

[rtl/shwd_word_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// shwd_word_if
// Valid/ready channel carrying one assembled word per beat.
// -----------------------------------------------------------------------------
interface shwd_word_if;
	logic        valid;
	logic        ready;
	logic [31:0] word_value;
	logic        frame_done;

	modport source (output valid, output word_value, output frame_done, input ready);
	modport sink   (input valid, input word_value, input frame_done, output ready);
endinterface
`default_nettype wire

[rtl/shwd_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// shwd_cfg_regs
// APB-style register file holding the deframer configuration.
// -----------------------------------------------------------------------------
module shwd_cfg_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [shwd_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [shwd_pkg::DATA_W-1:0]  pwdata,
	output logic      [shwd_pkg::DATA_W-1:0]  prdata,
	output logic                              pready,
	output shwd_pkg::cfg_t                    cfg
);
	import shwd_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_byte     <= HEADER_BYTE_RST;
			cfg_q.header_needed   <= HEADER_NEEDED_RST;
			cfg_q.delimiter_byte  <= DELIMITER_BYTE_RST;
			cfg_q.words_per_frame <= WORDS_PER_FRAME_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_HEADER_BYTE:     cfg_q.header_byte     <= pwdata[7:0];
				REG_HEADER_NEEDED:   cfg_q.header_needed   <= pwdata[7:0];
				REG_DELIMITER_BYTE:  cfg_q.delimiter_byte  <= pwdata[7:0];
				REG_WORDS_PER_FRAME: cfg_q.words_per_frame <= pwdata[7:0];
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_HEADER_BYTE:     prdata[7:0] = cfg_q.header_byte;
			REG_HEADER_NEEDED:   prdata[7:0] = cfg_q.header_needed;
			REG_DELIMITER_BYTE:  prdata[7:0] = cfg_q.delimiter_byte;
			REG_WORDS_PER_FRAME: prdata[7:0] = cfg_q.words_per_frame;
		endcase
	end

endmodule
`default_nettype wire

[rtl/shwd_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// shwd_core
// Input register, hunt/data update logic and result register.
// -----------------------------------------------------------------------------
module shwd_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  shwd_pkg::cfg_t      cfg,
	shwd_byte_if.sink           rx,
	shwd_word_if.source         wd
);
	import shwd_pkg::*;

	logic             vld_s1;
	logic [7:0]       byte_s1;

	logic             mode_q;
	logic [7:0]       mc_q;
	logic [7:0]       wc_q;
	logic [POS_W-1:0] pos_q;
	byte_buf_t        buf_q;

	logic             out_vld_q;
	logic [WORD_W-1:0] word_q;
	logic             done_q;

	logic             advance;
	logic             commit;

	logic             mode_d;
	logic [7:0]       mc_d;
	logic [7:0]       wc_d;
	logic [POS_W-1:0] pos_d;
	byte_buf_t        buf_d;
	logic             emit;
	logic             done_d;
	logic [7:0]       mc_upd;
	logic [7:0]       wc_inc;

	assign advance  = !out_vld_q || wd.ready;
	assign commit   = vld_s1 && advance;
	assign rx.ready = advance || !vld_s1;

	assign wd.valid      = out_vld_q;
	assign wd.word_value = word_q;
	assign wd.frame_done = done_q;

	always_comb begin
		mode_d = mode_q;
		mc_d   = mc_q;
		wc_d   = wc_q;
		pos_d  = pos_q;
		buf_d  = buf_q;
		emit   = 1'b0;
		done_d = 1'b0;
		wc_inc = wc_q + 8'd1;

		if (byte_s1 == cfg.header_byte)
			mc_upd = mc_q + 8'd1;
		else if (mc_q != 8'd0)
			mc_upd = mc_q - 8'd1;
		else
			mc_upd = mc_q;

		if (!mode_q) begin
			mc_d = mc_upd;
			if (mc_upd == cfg.header_needed) begin
				mc_d   = 8'd0;
				mode_d = 1'b1;
			end
		end else if (byte_s1 != cfg.delimiter_byte) begin
			if (pos_q < POS_W'(BYTES_PER_WORD)) begin
				for (int k = 0; k < BYTES_PER_WORD; k++) begin
					if (pos_q == POS_W'(k))
						buf_d[k] = byte_s1;
				end
				pos_d = pos_q + POS_W'(1);
			end
		end else begin
			emit  = 1'b1;
			pos_d = '0;
			wc_d  = wc_inc;
			if (wc_inc == cfg.words_per_frame) begin
				wc_d   = 8'd0;
				mode_d = 1'b0;
				done_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
			mode_q    <= 1'b0;
			mc_q      <= '0;
			wc_q      <= '0;
			pos_q     <= '0;
			buf_q     <= '0;
		end else begin
			if (rx.ready)
				vld_s1 <= rx.valid;
			if (advance)
				out_vld_q <= vld_s1 && emit;
			if (commit) begin
				mode_q <= mode_d;
				mc_q   <= mc_d;
				wc_q   <= wc_d;
				pos_q  <= pos_d;
				buf_q  <= buf_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready)
			byte_s1 <= rx.rx_byte;
		if (commit && emit) begin
			word_q <= build_word(buf_q);
			done_q <= done_d;
		end
	end

endmodule
`default_nettype wire

[rtl/sync_header_word_deframer.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// sync_header_word_deframer
// A delimiter beat yields its word through the input register and then the
// result register.
// Throughput: one byte per cycle; the result register holds while the output
// stalls and the input register keeps taking bytes until both are full.
// Reset: arst_n clears the hunt state, counters, byte buffer and loads the
// default configuration; no clearing pass.
// -----------------------------------------------------------------------------
module sync_header_word_deframer (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [shwd_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [shwd_pkg::DATA_W-1:0]  pwdata,
	output logic      [shwd_pkg::DATA_W-1:0]  prdata,
	output logic                              pready,
	shwd_byte_if.sink                         rx,
	shwd_word_if.source                       wd
);
	import shwd_pkg::*;

	cfg_t cfg;

	shwd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	shwd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.rx     (rx),
		.wd     (wd)
	);

endmodule
`default_nettype wire
